FILE: hdl/swms_pkg.sv
// ----------------------------------------------------------------------------
// swms_pkg
// Shared types and constants for the square-wave melody sequencer: command
// codes, configuration register indexes, field widths and reset values.
// ----------------------------------------------------------------------------
package swms_pkg;

  // Commands carried by an input item.
  typedef enum logic [1:0] {
    CMD_TICK    = 2'd0,
    CMD_LOAD    = 2'd1,
    CMD_PAUSE   = 2'd2,
    CMD_RESTART = 2'd3
  } cmd_t;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_SPB      = 2'd0,
    CFG_GAP      = 2'd1,
    CFG_SONG_LEN = 2'd2,
    CFG_AMP      = 2'd3
  } cfg_reg_t;

  // Field widths.
  localparam int SPB_W      = 26;
  localparam int GAP_W      = 16;
  localparam int SONG_LEN_W = 7;
  localparam int AMP_W      = 15;
  localparam int CFG_DATA_W = 26;
  localparam int CFG_IDX_W  = 2;
  localparam int IDX_W      = 6;
  localparam int STEP_W     = 32;
  localparam int QTR_W      = 6;
  localparam int SAMPLE_W   = 16;
  localparam int POS_W      = 6;
  localparam int ELAPSED_W  = 22;
  localparam int LEN_FRAC   = 10;

  // Largest song that the position counter can address.
  localparam int POS_LIMIT  = 2 ** POS_W;

  // Register reset values.
  localparam logic [SPB_W-1:0]      SPB_RST      = SPB_W'(9408000);
  localparam logic [GAP_W-1:0]      GAP_RST      = GAP_W'(1323);
  localparam logic [SONG_LEN_W-1:0] SONG_LEN_RST = SONG_LEN_W'(1);
  localparam logic [AMP_W-1:0]      AMP_RST      = AMP_W'(4096);

  // One note table entry.
  typedef struct packed {
    logic [STEP_W-1:0] step;
    logic [QTR_W-1:0]  quarters;
  } note_entry_t;

  localparam int ENTRY_W = $bits(note_entry_t);

endpackage

FILE: hdl/swms_channel_if.sv
// ----------------------------------------------------------------------------
// swms_in_if / swms_out_if
// Valid/ready channels for command items into the sequencer and for the
// result items that it returns.
// ----------------------------------------------------------------------------
interface swms_in_if;
  import swms_pkg::*;

  logic                 valid;
  logic                 ready;
  cmd_t                 command;
  logic [IDX_W-1:0]     entry_index;
  logic [STEP_W-1:0]    phase_step;
  logic [QTR_W-1:0]     duration_quarters;

  modport source (output valid, command, entry_index, phase_step, duration_quarters,
                  input ready);
  modport sink   (input valid, command, entry_index, phase_step, duration_quarters,
                  output ready);
endinterface

interface swms_out_if;
  import swms_pkg::*;

  logic                        valid;
  logic                        ready;
  logic signed [SAMPLE_W-1:0]  sample;
  logic [POS_W-1:0]            note_position;
  logic                        paused;
  logic                        sounding;

  modport source (output valid, sample, note_position, paused, sounding, input ready);
  modport sink   (input valid, sample, note_position, paused, sounding, output ready);
endinterface

FILE: hdl/swms_ram.sv
// ----------------------------------------------------------------------------
// swms_ram
// Generic RAM with one write port and two read ports; read data is
// registered and updates only when a read is enabled.
// ----------------------------------------------------------------------------
module swms_ram #(
  parameter  int WIDTH = 38,
  parameter  int DEPTH = 64,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_a,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Two registered read ports.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

FILE: hdl/square_wave_melody_sequencer_top.sv
// Path: an accepted input item is captured in the input stage register, then moves to the
// result register, where it is held for as long as the result side stalls.
// Throughput: one item per cycle unless the result side stalls; the note table RAM is
// read on acceptance, at the two entries that may follow the current note, so none waits.
// Reset (rst_n, synchronous): clears position, counters, pause and the registers to
// their defaults. The note table is not cleared and must be loaded before it is played.
// ----------------------------------------------------------------------------
// square_wave_melody_sequencer_top
// Plays a table of square-wave notes one sample per tick, with a gap of silence at the end
// of each note no shorter than the gap; takes load, pause and restart commands.
// ----------------------------------------------------------------------------
module square_wave_melody_sequencer_top #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic                             clk,
  input  logic                             rst_n,
  swms_in_if.sink                          in_ch,
  swms_out_if.source                       out_ch,
  input  logic                             cfg_we,
  input  logic [swms_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [swms_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import swms_pkg::*;

  localparam int AW      = $clog2(TABLE_DEPTH);
  localparam int EFF_MAX = (TABLE_DEPTH < POS_LIMIT) ? TABLE_DEPTH : POS_LIMIT;
  localparam logic [SONG_LEN_W-1:0] EFF_MAX_L = SONG_LEN_W'(EFF_MAX);
  localparam logic [SONG_LEN_W-1:0] ONE_L     = SONG_LEN_W'(1);

  // Position that follows p in a song of n entries.
  function automatic logic [POS_W-1:0] next_pos(input logic [POS_W-1:0]      p,
                                                input logic [SONG_LEN_W-1:0] n);
    logic [SONG_LEN_W-1:0] inc;
    inc = SONG_LEN_W'(p) + ONE_L;
    return (inc >= n) ? '0 : POS_W'(inc);
  endfunction

  // Configuration registers.
  logic [SPB_W-1:0]      spb_r;
  logic [GAP_W-1:0]      gap_r;
  logic [SONG_LEN_W-1:0] song_len_r;
  logic [AMP_W-1:0]      amp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spb_r      <= SPB_RST;
      gap_r      <= GAP_RST;
      song_len_r <= SONG_LEN_RST;
      amp_r      <= AMP_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_SPB:      spb_r      <= cfg_wdata[SPB_W-1:0];
        CFG_GAP:      gap_r      <= cfg_wdata[GAP_W-1:0];
        CFG_SONG_LEN: song_len_r <= cfg_wdata[SONG_LEN_W-1:0];
        CFG_AMP:      amp_r      <= cfg_wdata[AMP_W-1:0];
      endcase
    end
  end

  // Effective song length: zero counts as one, limited by the table size and position range.
  logic [SONG_LEN_W-1:0] eff_len;
  always_comb begin
    if (song_len_r == '0) begin
      eff_len = ONE_L;
    end else if (song_len_r > EFF_MAX_L) begin
      eff_len = EFF_MAX_L;
    end else begin
      eff_len = song_len_r;
    end
  end

  // Player state.
  logic [POS_W-1:0]     position_r, position_nxt;
  logic [ELAPSED_W-1:0] elapsed_r, elapsed_nxt;
  logic [STEP_W-1:0]    active_r, active_nxt;
  logic [STEP_W-1:0]    phase_r, phase_nxt;
  logic                 pause_r, pause_nxt;
  logic [QTR_W-1:0]     cur_q_r, cur_q_nxt;
  note_entry_t          sh0_r, sh1_r;

  // Input stage register.
  logic                 s1_valid_r;
  cmd_t                 s1_cmd_r;
  logic [IDX_W-1:0]     s1_idx_r;
  logic [STEP_W-1:0]    s1_step_r;
  logic [QTR_W-1:0]     s1_qtr_r;
  logic                 prev_adv_r;
  logic                 prev_rst_r;

  // Result register.
  logic                       out_valid_r;
  logic signed [SAMPLE_W-1:0] out_sample_r;
  logic [POS_W-1:0]           out_pos_r;
  logic                       out_paused_r;
  logic                       out_sounding_r;

  logic s1_fire, in_fire;
  logic adv, is_restart;

  assign s1_fire     = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_fire;
  assign in_fire     = in_ch.valid && in_ch.ready;

  // Candidate next entries: after the current position, and one further on for
  // the case that the item ahead advances.
  logic [POS_W-1:0] pos_a, pos_b;
  assign pos_a = next_pos(position_r, eff_len);
  assign pos_b = next_pos(pos_a, eff_len);

  logic        ram_we;
  note_entry_t ram_wdata;
  note_entry_t rd_a, rd_b;

  assign ram_we = in_fire && (in_ch.command == CMD_LOAD)
                  && (int'(in_ch.entry_index) < TABLE_DEPTH);
  assign ram_wdata.step     = in_ch.phase_step;
  assign ram_wdata.quarters = in_ch.duration_quarters;

  swms_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_note_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (AW'(in_ch.entry_index)),
    .wdata   (ram_wdata),
    .re      (in_fire),
    .raddr_a (AW'(pos_a)),
    .raddr_b (AW'(pos_b)),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  // Input stage capture, with how the item ahead moved the position.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s1_cmd_r   <= CMD_TICK;
      prev_adv_r <= 1'b0;
      prev_rst_r <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_r <= 1'b1;
        s1_cmd_r   <= in_ch.command;
        prev_adv_r <= s1_fire && adv;
        prev_rst_r <= s1_fire && is_restart;
      end else if (s1_fire) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_idx_r  <= in_ch.entry_index;
      s1_step_r <= in_ch.phase_step;
      s1_qtr_r  <= in_ch.duration_quarters;
    end
  end

  // Entry that follows the position this item sees.
  note_entry_t next_entry;
  always_comb begin
    if (prev_rst_r) begin
      next_entry = (eff_len == ONE_L) ? sh0_r : sh1_r;
    end else if (prev_adv_r) begin
      next_entry = rd_b;
    end else begin
      next_entry = rd_a;
    end
  end

  // Note length and per-item datapath.
  logic [QTR_W+SPB_W-1:0]     prod;
  logic [ELAPSED_W-1:0]       note_len, gap_ext, el_inc;
  logic                       load_ok;
  logic signed [SAMPLE_W-1:0] amp_s;
  logic signed [SAMPLE_W-1:0] sample_nxt;

  assign prod     = (QTR_W+SPB_W)'(cur_q_r) * (QTR_W+SPB_W)'(spb_r);
  assign note_len = prod[QTR_W+SPB_W-1:LEN_FRAC];
  assign gap_ext  = ELAPSED_W'(gap_r);
  assign el_inc   = elapsed_r + ELAPSED_W'(1);
  assign load_ok  = int'(s1_idx_r) < TABLE_DEPTH;
  assign amp_s    = signed'({1'b0, amp_r});

  always_comb begin
    position_nxt = position_r;
    elapsed_nxt  = elapsed_r;
    active_nxt   = active_r;
    phase_nxt    = phase_r;
    pause_nxt    = pause_r;
    cur_q_nxt    = cur_q_r;
    sample_nxt   = '0;
    adv          = 1'b0;
    is_restart   = 1'b0;
    unique case (s1_cmd_r)
      CMD_LOAD: begin
        // A load into the playing entry changes its length at once.
        if (load_ok && (s1_idx_r == position_r)) begin
          cur_q_nxt = s1_qtr_r;
        end
      end
      CMD_PAUSE: begin
        pause_nxt = ~pause_r;
      end
      CMD_RESTART: begin
        position_nxt = '0;
        elapsed_nxt  = '0;
        active_nxt   = sh0_r.step;
        cur_q_nxt    = sh0_r.quarters;
        pause_nxt    = 1'b0;
        is_restart   = 1'b1;
      end
      CMD_TICK: begin
        if (!pause_r) begin
          elapsed_nxt = el_inc;
          // Gap silence near the end of the note.
          if ((note_len >= gap_ext) && (el_inc >= note_len - gap_ext)) begin
            active_nxt = '0;
          end
          // End of note: move to the next entry.
          if (el_inc >= note_len) begin
            elapsed_nxt  = '0;
            position_nxt = pos_a;
            active_nxt   = next_entry.step;
            cur_q_nxt    = next_entry.quarters;
            adv          = 1'b1;
          end
          if (active_nxt != '0) begin
            sample_nxt = phase_r[STEP_W-1] ? -amp_s : amp_s;
            phase_nxt  = phase_r + active_nxt;
          end else begin
            phase_nxt = '0;
          end
        end
      end
    endcase
  end

  // State update as each item completes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      position_r <= '0;
      elapsed_r  <= '0;
      active_r   <= '0;
      phase_r    <= '0;
      pause_r    <= 1'b0;
      cur_q_r    <= '0;
    end else if (s1_fire) begin
      position_r <= position_nxt;
      elapsed_r  <= elapsed_nxt;
      active_r   <= active_nxt;
      phase_r    <= phase_nxt;
      pause_r    <= pause_nxt;
      cur_q_r    <= cur_q_nxt;
    end
  end

  // Copies of entries zero and one for restart.
  always_ff @(posedge clk) begin
    if (s1_fire && (s1_cmd_r == CMD_LOAD) && load_ok) begin
      if (s1_idx_r == IDX_W'(0)) begin
        sh0_r.step     <= s1_step_r;
        sh0_r.quarters <= s1_qtr_r;
      end
      if (s1_idx_r == IDX_W'(1)) begin
        sh1_r.step     <= s1_step_r;
        sh1_r.quarters <= s1_qtr_r;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_sample_r   <= sample_nxt;
      out_pos_r      <= position_nxt;
      out_paused_r   <= pause_nxt;
      out_sounding_r <= (active_nxt != '0) && !pause_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.sample        = out_sample_r;
  assign out_ch.note_position = out_pos_r;
  assign out_ch.paused        = out_paused_r;
  assign out_ch.sounding      = out_sounding_r;

  // The position never leaves the addressable song.
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    SONG_LEN_W'(position_r) < EFF_MAX_L)
    else $error("position beyond table");

  // The item ahead either advanced or restarted, never both.
  a_prev_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(prev_adv_r && prev_rst_r))
    else $error("conflicting next-entry select");

  // A nonzero sample only comes from a sounding note.
  a_sample_sounding: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_sample_r != '0)) |-> out_sounding_r)
    else $error("sample without sounding note");

  // Moving to the next note restarts the sample count.
  a_adv_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && adv) |=> (elapsed_r == '0))
    else $error("elapsed not cleared on advance");

endmodule

FILE: dv/melody_tb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Melody sequencer scoreboard
// Item types and a tracker class that follows the player's state on every
// accepted command item. It queues the result item that the block should
// return and checks the returned items against that queue in order.
// ----------------------------------------------------------------------------
package melody_tb_pkg;
  import swms_pkg::*;

  localparam int NOTE_SLOTS = 64;

  // One command item as driven into the block.
  typedef struct {
    cmd_t              command;
    logic [IDX_W-1:0]  entry_index;
    logic [STEP_W-1:0] phase_step;
    logic [QTR_W-1:0]  duration_quarters;
  } melody_cmd_item_t;

  // One result item as returned by the block.
  typedef struct {
    logic signed [SAMPLE_W-1:0] sample;
    logic [POS_W-1:0]           note_position;
    logic                       paused;
    logic                       sounding;
  } melody_result_t;

  class melody_tracker;
    // Player state, mirrored from the block.
    note_entry_t            notes[NOTE_SLOTS];
    logic [POS_W-1:0]       position;
    logic [ELAPSED_W-1:0]   elapsed;
    logic [STEP_W-1:0]      active_step;
    logic [STEP_W-1:0]      phase_acc;
    logic                   pause_flag;

    // Register copies.
    logic [SPB_W-1:0]       spb;
    logic [GAP_W-1:0]       gap;
    logic [SONG_LEN_W-1:0]  song_len;
    logic [AMP_W-1:0]       amplitude;

    melody_result_t         expected_results[$];
    int errors;
    int checked;
    int items_seen;
    int ticks_seen;
    int advances;
    int gap_silences;

    function new();
      foreach (notes[i]) notes[i] = '0;
      position     = '0;
      elapsed      = '0;
      active_step  = '0;
      phase_acc    = '0;
      pause_flag   = 1'b0;
      spb          = SPB_RST;
      gap          = GAP_RST;
      song_len     = SONG_LEN_RST;
      amplitude    = AMP_RST;
      errors       = 0;
      checked      = 0;
      items_seen   = 0;
      ticks_seen   = 0;
      advances     = 0;
      gap_silences = 0;
    endfunction

    function void set_register(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        CFG_SPB:      spb       = value[SPB_W-1:0];
        CFG_GAP:      gap       = value[GAP_W-1:0];
        CFG_SONG_LEN: song_len  = value[SONG_LEN_W-1:0];
        CFG_AMP:      amplitude = value[AMP_W-1:0];
        default: ;
      endcase
    endfunction

    // Number of entries the song wraps at: zero counts as one, capped at the table.
    function int song_span();
      int n;
      n = int'(song_len);
      if (n == 0) n = 1;
      if (n > NOTE_SLOTS) n = NOTE_SLOTS;
      if (n > POS_LIMIT) n = POS_LIMIT;
      return n;
    endfunction

    // Advance the player by one command item and return what it should output.
    function melody_result_t play_command(melody_cmd_item_t c);
      melody_result_t r;
      logic [63:0]    product;
      logic [31:0]    note_len;
      r.sample = '0;
      case (c.command)
        CMD_LOAD: begin
          notes[c.entry_index].step     = c.phase_step;
          notes[c.entry_index].quarters = c.duration_quarters;
        end
        CMD_PAUSE: begin
          pause_flag = ~pause_flag;
        end
        CMD_RESTART: begin
          position    = '0;
          elapsed     = '0;
          active_step = notes[0].step;
          pause_flag  = 1'b0;
        end
        default: begin
          ticks_seen++;
          if (!pause_flag) begin
            elapsed  = elapsed + 1'b1;
            product  = 64'(notes[position].quarters) * 64'(spb);
            note_len = 32'(product >> LEN_FRAC);
            // Silence the tail of the note, unless the gap is longer than the note.
            if (note_len >= 32'(gap) && 32'(elapsed) >= note_len - 32'(gap)) begin
              active_step = '0;
              gap_silences++;
            end
            // End of note: move on and wrap at the song end.
            if (32'(elapsed) >= note_len) begin
              elapsed = '0;
              if (int'(position) + 1 >= song_span()) position = '0;
              else position = position + 1'b1;
              active_step = notes[position].step;
              advances++;
            end
            if (active_step != '0) begin
              r.sample  = phase_acc[STEP_W-1] ? -$signed({1'b0, amplitude})
                                              :  $signed({1'b0, amplitude});
              phase_acc = phase_acc + active_step;
            end else begin
              phase_acc = '0;
            end
          end
        end
      endcase
      r.note_position = position;
      r.paused        = pause_flag;
      r.sounding      = (active_step != '0) && !pause_flag;
      return r;
    endfunction

    function void accept_command(melody_cmd_item_t c);
      items_seen++;
      expected_results.push_back(play_command(c));
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    task report(string msg);
      $display("[%0t] MISMATCH: %s", $time, msg);
      errors++;
    endtask

    task check_result(melody_result_t got);
      melody_result_t exp;
      if (expected_results.size() == 0) begin
        report("result item arrived with no expectation pending");
        return;
      end
      exp = expected_results.pop_front();
      checked++;
      if (got.sample !== exp.sample)
        report($sformatf("result %0d sample: got %0d, expected %0d",
                         checked, got.sample, exp.sample));
      if (got.note_position !== exp.note_position)
        report($sformatf("result %0d note_position: got %0d, expected %0d",
                         checked, got.note_position, exp.note_position));
      if (got.paused !== exp.paused)
        report($sformatf("result %0d paused: got %b, expected %b",
                         checked, got.paused, exp.paused));
      if (got.sounding !== exp.sounding)
        report($sformatf("result %0d sounding: got %b, expected %b",
                         checked, got.sounding, exp.sounding));
    endtask
  endclass

endpackage

FILE: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Square-wave melody sequencer testbench
// Fills the note table, runs a short directed song through every command, then
// plays random command streams under several register settings, with random
// stalls on both channels save under the last. Every result item is checked in order.
// ----------------------------------------------------------------------------
module testbench;
  import swms_pkg::*;
  import melody_tb_pkg::*;

  localparam int NUM_PHASES   = 8;
  localparam int PHASE_ITEMS  = 90;
  localparam int LONG_HOLD    = 80;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 10;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  swms_in_if  in_ch ();
  swms_out_if out_ch ();

  melody_tracker tracker;
  bit idle_on;
  int long_hold_req;
  int phases_run;
  int stall_count;

  square_wave_melody_sequencer_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver side: random ready bursts, plus one long hold-off on request.
  initial begin
    int hold_left;
    hold_left = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_req > 0) begin
        hold_left     = long_hold_req;
        long_hold_req = 0;
      end
      if (hold_left > 0) begin
        out_ch.ready = 1'b0;
        hold_left--;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        out_ch.ready = 1'b0;
        hold_left    = $urandom_range(1, 6) - 1;
      end else begin
        out_ch.ready = 1'b1;
      end
    end
  end

  // Result monitor.
  always @(posedge clk) begin
    melody_result_t got;
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      got.sample        = out_ch.sample;
      got.note_position = out_ch.note_position;
      got.paused        = out_ch.paused;
      got.sounding      = out_ch.sounding;
      tracker.check_result(got);
    end
  end

  // Watchdog: ends the run when neither channel moves an item for too long.
  initial begin
    stall_count = 0;
    while (stall_count < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
          (out_ch.valid === 1'b1 && out_ch.ready === 1'b1))
        stall_count = 0;
      else
        stall_count++;
    end
    $display("[%0t] Watchdog: no item moved for %0d cycles", $time, STALL_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic melody_cmd_item_t make_item(cmd_t cmd, logic [IDX_W-1:0] idx,
                                                 logic [STEP_W-1:0] step,
                                                 logic [QTR_W-1:0] qtr);
    melody_cmd_item_t it;
    it.command           = cmd;
    it.entry_index       = idx;
    it.phase_step        = step;
    it.duration_quarters = qtr;
    return it;
  endfunction

  // Note content: rests and full-scale steps show up often, lengths are mostly short.
  function automatic logic [STEP_W-1:0] random_step();
    int r;
    r = $urandom_range(0, 99);
    if (r < 20) return '0;
    if (r < 30) return '1;
    return $urandom;
  endfunction

  function automatic logic [QTR_W-1:0] random_quarters();
    if ($urandom_range(0, 9) < 6) return QTR_W'($urandom_range(0, 4));
    return QTR_W'($urandom_range(0, 63));
  endfunction

  // Mostly ticks, so notes play out; loads, pauses and restarts mixed in.
  function automatic melody_cmd_item_t random_item();
    melody_cmd_item_t it;
    int r;
    r = $urandom_range(0, 99);
    it = make_item(CMD_TICK, IDX_W'($urandom_range(0, 63)), $urandom,
                   QTR_W'($urandom_range(0, 63)));
    if (r >= 72 && r < 87) begin
      it.command           = CMD_LOAD;
      it.phase_step        = random_step();
      it.duration_quarters = random_quarters();
    end else if (r >= 87 && r < 93) begin
      it.command = CMD_PAUSE;
    end else if (r >= 93) begin
      it.command = CMD_RESTART;
    end
    return it;
  endfunction

  // Offer one item at the falling edge and hold it until it is accepted.
  task automatic send_item(melody_cmd_item_t it);
    @(negedge clk);
    if (idle_on && $urandom_range(0, 7) == 0) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_ch.valid             = 1'b1;
    in_ch.command           = it.command;
    in_ch.entry_index       = it.entry_index;
    in_ch.phase_step        = it.phase_step;
    in_ch.duration_quarters = it.duration_quarters;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    tracker.accept_command(it);
  endtask

  // Stop offering and wait until every expected result has come back.
  task automatic wait_idle();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = value;
    tracker.set_register(idx, value);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic program_registers(int spb, int gap, int song, int amp);
    wait_idle();
    write_reg(CFG_SPB,      CFG_DATA_W'(spb));
    write_reg(CFG_GAP,      CFG_DATA_W'(gap));
    write_reg(CFG_SONG_LEN, CFG_DATA_W'(song));
    write_reg(CFG_AMP,      CFG_DATA_W'(amp));
    phases_run++;
  endtask

  // Main sequence.
  initial begin
    tracker       = new();
    idle_on       = 1'b1;
    long_hold_req = 0;
    phases_run    = 0;
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_wdata     = '0;
    in_ch.valid             = 1'b0;
    in_ch.command           = CMD_TICK;
    in_ch.entry_index       = '0;
    in_ch.phase_step        = '0;
    in_ch.duration_quarters = '0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    // Load every table entry before any tick can play one.
    for (int i = 0; i < NOTE_SLOTS; i++)
      send_item(make_item(CMD_LOAD, IDX_W'(i), random_step(), random_quarters()));

    // Directed song: length equals quarters, one-sample gap, four entries.
    program_registers(1024, 1, 4, 32767);
    send_item(make_item(CMD_LOAD, 0, 32'h8000_0000, 3));
    send_item(make_item(CMD_LOAD, 1, 32'h0000_0000, 2));  // rest
    send_item(make_item(CMD_LOAD, 2, 32'hFFFF_FFFF, 0));  // zero length, gap longer
    send_item(make_item(CMD_LOAD, 3, 32'h1234_5678, 1));
    send_item(make_item(CMD_RESTART, 6'h3F, 32'hFFFF_FFFF, 6'h3F));
    repeat (12) send_item(make_item(CMD_TICK, 0, 0, 0));
    send_item(make_item(CMD_PAUSE, 0, 0, 0));
    send_item(make_item(CMD_TICK, 6'h3F, 32'hFFFF_FFFF, 6'h3F));  // paused tick
    send_item(make_item(CMD_TICK, 0, 0, 0));
    send_item(make_item(CMD_PAUSE, 0, 0, 0));
    send_item(make_item(CMD_TICK, 0, 0, 0));
    send_item(make_item(CMD_PAUSE, 0, 0, 0));
    send_item(make_item(CMD_RESTART, 0, 0, 0));  // restart also unpauses
    send_item(make_item(CMD_TICK, 0, 0, 0));
    send_item(make_item(CMD_LOAD, 63, 32'hFFFF_FFFF, 63));

    // Random phases, each under its own register setting.
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: program_registers(1, 0, 64, 0);
        1: program_registers(33868800, 65535, 1, 32767);
        2: program_registers($urandom_range(256, 4096), $urandom_range(0, 6), 0,
                             $urandom_range(0, 32767));
        3: program_registers($urandom_range(256, 4096), $urandom_range(0, 6), 127,
                             $urandom_range(0, 32767));
        default: program_registers($urandom_range(256, 4096),
                                   ($urandom_range(0, 1) == 0) ? $urandom_range(0, 6)
                                                               : $urandom_range(0, 65535),
                                   $urandom_range(1, 64), $urandom_range(0, 32767));
      endcase
      // The last phase runs with both sides always ready.
      if (p == NUM_PHASES - 1) idle_on = 1'b0;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // Back-pressure the result side long enough for the block to fill up.
        if (p == 2 && i == 20) long_hold_req = LONG_HOLD;
        send_item(random_item());
      end
    end

    // Drain and finish.
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.pending() != 0)
      tracker.report($sformatf("%0d expected results never arrived", tracker.pending()));
    $display("Run covered %0d command items (%0d ticks) under %0d register settings.",
             tracker.items_seen, tracker.ticks_seen, phases_run);
    $display("Checked %0d result items; %0d note changes and %0d gap-silenced ticks seen.",
             tracker.checked, tracker.advances, tracker.gap_silences);
    if (tracker.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
